// ----- rtl/mpsa_pkg.sv -----
// ============================================================================
// mpsa_pkg
// Shared types and constants for the multi-pattern Shift-And matcher core.
// ============================================================================
`default_nettype none

package mpsa_pkg;

    localparam int SYMBOL_W   = 8;
    localparam int COMMAND_W  = 2;
    localparam int POSITION_W = 32;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_SCAN    = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    // Table control from the search stage to the character table.
    typedef struct packed {
        logic                wr_en;   // set one bit in the symbol's table word
        logic                clear;   // drop every table word
        logic [SYMBOL_W-1:0] symbol;  // symbol being loaded
    } tbl_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/mpsa_char_table.sv -----
// ============================================================================
// mpsa_char_table
// Per-symbol table words in a memory with registered read, valid bits that
// all clear together, and a bypass for a write that lands with the read.
// ============================================================================
`default_nettype none

module mpsa_char_table #(
    parameter int STATE_BITS    = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   rd_en,
    input  wire logic [mpsa_pkg::SYMBOL_W-1:0]          rd_symbol,
    input  wire mpsa_pkg::tbl_ctl_t                     ctl,
    input  wire logic [$clog2(STATE_BITS)-1:0]          wr_bit,
    output logic      [STATE_BITS-1:0]                  table_word
);
    import mpsa_pkg::*;

    localparam int AW = $clog2(ALPHABET_SIZE);

    logic [STATE_BITS-1:0]    mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] valid_reg;
    logic [ALPHABET_SIZE-1:0] valid_next;

    logic [STATE_BITS-1:0] rd_data_reg;
    logic                  rd_ok_reg;
    logic                  rd_range_reg;
    logic                  byp_hit_reg;
    logic                  byp_fresh_reg;
    logic [STATE_BITS-1:0] byp_word_reg;

    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  rd_in_range;
    logic                  wr_go;
    logic [STATE_BITS-1:0] wr_onehot;

    assign rd_addr     = rd_symbol[AW-1:0];
    assign wr_addr     = ctl.symbol[AW-1:0];
    assign rd_in_range = {1'b0, rd_symbol} < (SYMBOL_W+1)'(ALPHABET_SIZE);
    assign wr_go       = ctl.wr_en && ({1'b0, ctl.symbol} < (SYMBOL_W+1)'(ALPHABET_SIZE));
    assign wr_onehot   = STATE_BITS'(1) << wr_bit;

    always_comb begin
        valid_next = valid_reg;
        if (ctl.clear) begin
            valid_next = '0;
        end else if (wr_go) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // A first write after a clear replaces the stale word.
    always_ff @(posedge aclk) begin
        if (wr_go) begin
            if (!valid_reg[wr_addr]) begin
                mem[wr_addr] <= wr_onehot;
            end else begin
                mem[wr_addr][wr_bit] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg   <= mem[rd_addr];
            rd_ok_reg     <= valid_next[rd_addr];
            rd_range_reg  <= rd_in_range;
            byp_hit_reg   <= wr_go && (wr_addr == rd_addr);
            byp_fresh_reg <= !valid_reg[wr_addr];
            byp_word_reg  <= wr_onehot;
        end
    end

    always_comb begin
        if (!rd_range_reg) begin
            table_word = '0;
        end else if (byp_hit_reg) begin
            table_word = byp_fresh_reg ? byp_word_reg : (rd_data_reg | byp_word_reg);
        end else if (rd_ok_reg) begin
            table_word = rd_data_reg;
        end else begin
            table_word = '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/multi_pattern_shift_and_matcher_core.sv -----
// ============================================================================
// multi_pattern_shift_and_matcher_core
// Multi-pattern Shift-And (bitap) text matcher with a per-symbol table.
// ============================================================================
//
//  channel  | direction | payload                                  | handshake
//  ---------+-----------+------------------------------------------+---------------
//  request  | in        | s_command, s_symbol, s_pattern_last      | s_valid/s_ready
//  result   | out       | m_matched, m_position, m_end_hits,       | m_valid/m_ready
//           |           | m_overflow                               |
//
//  Accepting a request registers it and reads its table word; when the request
//  stage advances, the shift-and-or is written into the result register, and one
//  request is accepted per cycle while results drain.
//  Synchronous active-low reset empties both stages and the table.
//  A stalled result holds the request stage; a new request enters only while
//  that stage is empty or advancing.
//
`default_nettype none

module multi_pattern_shift_and_matcher_core #(
    parameter int STATE_BITS    = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // request channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [mpsa_pkg::COMMAND_W-1:0]       s_command,
    input  wire logic [mpsa_pkg::SYMBOL_W-1:0]        s_symbol,
    input  wire logic                                 s_pattern_last,
    // result channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_matched,
    output logic      [mpsa_pkg::POSITION_W-1:0]      m_position,
    output logic      [STATE_BITS-1:0]                m_end_hits,
    output logic                                      m_overflow
);
    import mpsa_pkg::*;

    localparam int BI_W = $clog2(STATE_BITS);
    localparam int NB_W = BI_W + 1;

    // Request stage: the request waits here while its table word is read.
    logic                stg_valid_reg;
    cmd_t                stg_cmd_reg;
    logic [SYMBOL_W-1:0] stg_sym_reg;
    logic                stg_last_reg;

    // Search state.
    logic [STATE_BITS-1:0] match_reg, match_next;
    logic [STATE_BITS-1:0] start_reg, start_next;
    logic [STATE_BITS-1:0] end_reg,   end_next;
    logic [NB_W-1:0]       next_bit_reg, next_bit_next;
    logic                  at_start_reg, at_start_next;
    logic [POSITION_W-1:0] text_index_reg, text_index_next;

    // Result register.
    logic                  m_valid_reg;
    logic                  m_matched_reg,  m_matched_next;
    logic [POSITION_W-1:0] m_position_reg, m_position_next;
    logic [STATE_BITS-1:0] m_end_hits_reg, m_end_hits_next;
    logic                  m_overflow_reg, m_overflow_next;

    logic                  advance;
    logic                  accept;
    logic                  fits;
    logic [STATE_BITS-1:0] load_bit;
    logic [STATE_BITS-1:0] table_word;
    logic [STATE_BITS-1:0] scan_bits;
    tbl_ctl_t              tbl_ctl;

    // Advance the search stage whenever the request stage holds a request and the result register is free or drains.
    assign advance = stg_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stg_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign fits     = next_bit_reg < NB_W'(STATE_BITS);
    assign load_bit = STATE_BITS'(1) << next_bit_reg[BI_W-1:0];

    assign tbl_ctl.wr_en  = advance && (stg_cmd_reg == CMD_LOAD) && fits;
    assign tbl_ctl.clear  = advance && (stg_cmd_reg == CMD_CLEAR);
    assign tbl_ctl.symbol = stg_sym_reg;

    mpsa_char_table #(
        .STATE_BITS    (STATE_BITS),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (accept),
        .rd_symbol  (s_symbol),
        .ctl        (tbl_ctl),
        .wr_bit     (next_bit_reg[BI_W-1:0]),
        .table_word (table_word)
    );

    assign scan_bits = ((match_reg << 1) | start_reg) & table_word;

    always_comb begin
        match_next      = match_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        next_bit_next   = next_bit_reg;
        at_start_next   = at_start_reg;
        text_index_next = text_index_reg;
        m_matched_next  = 1'b0;
        m_position_next = '0;
        m_end_hits_next = '0;
        m_overflow_next = 1'b0;
        case (stg_cmd_reg)
            CMD_CLEAR: begin
                match_next      = '0;
                start_next      = '0;
                end_next        = '0;
                next_bit_next   = '0;
                at_start_next   = 1'b1;
                text_index_next = '0;
            end
            CMD_LOAD: begin
                if (!fits) begin
                    m_overflow_next = 1'b1;
                end else begin
                    // Mark the first and last bits of the pattern in the same order.
                    if (at_start_reg) begin
                        start_next = start_reg | load_bit;
                    end
                    if (stg_last_reg) begin
                        end_next = end_reg | load_bit;
                    end
                    at_start_next = stg_last_reg;
                    next_bit_next = next_bit_reg + NB_W'(1);
                end
            end
            CMD_SCAN: begin
                match_next      = scan_bits;
                m_end_hits_next = scan_bits & end_reg;
                m_matched_next  = |(scan_bits & end_reg);
                m_position_next = text_index_reg;
                text_index_next = text_index_reg + POSITION_W'(1);
            end
            CMD_RESTART: begin
                match_next      = '0;
                text_index_next = '0;
            end
            default: begin
                match_next = match_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            match_reg      <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            next_bit_reg   <= '0;
            at_start_reg   <= 1'b1;
            text_index_reg <= '0;
        end else begin
            if (accept) begin
                stg_valid_reg <= 1'b1;
            end else if (advance) begin
                stg_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg    <= 1'b1;
                match_reg      <= match_next;
                start_reg      <= start_next;
                end_reg        <= end_next;
                next_bit_reg   <= next_bit_next;
                at_start_reg   <= at_start_next;
                text_index_reg <= text_index_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request payload until it advances.
    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_cmd_reg  <= cmd_t'(s_command);
            stg_sym_reg  <= s_symbol;
            stg_last_reg <= s_pattern_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_matched_reg  <= m_matched_next;
            m_position_reg <= m_position_next;
            m_end_hits_reg <= m_end_hits_next;
            m_overflow_reg <= m_overflow_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_matched  = m_matched_reg;
    assign m_position = m_position_reg;
    assign m_end_hits = m_end_hits_reg;
    assign m_overflow = m_overflow_reg;

endmodule

`default_nettype wire

// ----- rtl/mpsa_checker.sv -----
// ============================================================================
// mpsa_checker
// Port-level checks on the result channel of the matcher core.
// ============================================================================
`default_nettype none

module mpsa_checker #(
    parameter int STATE_BITS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic                              m_matched,
    input  wire logic [mpsa_pkg::POSITION_W-1:0]   m_position,
    input  wire logic [STATE_BITS-1:0]             m_end_hits,
    input  wire logic                              m_overflow
);

    // A stalled result stays valid with its end hits and position unchanged.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_end_hits) && $stable(m_position))
        else $error("stalled result changed");

    a_matched_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_matched == (m_end_hits != '0)))
        else $error("matched disagrees with end hits");

    a_overflow_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> !m_matched && (m_end_hits == '0) && (m_position == '0))
        else $error("overflow result carries search data");

    a_hits_stable_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |=> !m_valid || (m_matched == (m_end_hits != '0)))
        else $error("new result inconsistent");

endmodule

bind multi_pattern_shift_and_matcher_core mpsa_checker #(
    .STATE_BITS (STATE_BITS)
) u_mpsa_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_matched  (m_matched),
    .m_position (m_position),
    .m_end_hits (m_end_hits),
    .m_overflow (m_overflow)
);

`default_nettype wire

// ----- tb/multi_pattern_shift_and_matcher_core_tb.sv -----
// ============================================================================
// multi_pattern_shift_and_matcher_core_tb
// Self-checking bench for the multi-pattern Shift-And matcher core: drives
// pattern loads, text scans, restarts and clears through the request channel
// and checks every result against a cycle-free model of the bitap table.
// ============================================================================
`default_nettype none

module multi_pattern_shift_and_matcher_core_tb;

    import mpsa_pkg::*;

    localparam int VEC_W = 64;

    // One expected result, laid out like the result channel payload.
    typedef struct packed {
        logic                  matched;
        logic [POSITION_W-1:0] position;
        logic [VEC_W-1:0]      end_hits;
        logic                  overflow;
    } match_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the pattern table and search state,
    // predicts one result per accepted request and matches it in order.
    // ------------------------------------------------------------------------
    class match_scoreboard;
        logic [VEC_W-1:0]      sym_words [256];
        logic [VEC_W-1:0]      active_bits;
        logic [VEC_W-1:0]      start_bits;
        logic [VEC_W-1:0]      end_bits;
        int unsigned           fill;
        bit                    at_start;
        logic [POSITION_W-1:0] text_pos;
        match_result_t         expected_q [$];
        int unsigned           errors;

        function new();
            errors = 0;
            clear_patterns();
        endfunction

        function void clear_patterns();
            foreach (sym_words[i]) sym_words[i] = '0;
            active_bits = '0;
            start_bits  = '0;
            end_bits    = '0;
            fill        = 0;
            at_start    = 1'b1;
            text_pos    = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_request(cmd_t cmd, logic [SYMBOL_W-1:0] sym, logic last);
            match_result_t    r;
            logic [VEC_W-1:0] slot;
            r = '0;
            case (cmd)
                CMD_CLEAR: begin
                    clear_patterns();
                end
                CMD_LOAD: begin
                    if (fill >= VEC_W) begin
                        // packing full: drop the character, flag it
                        r.overflow = 1'b1;
                    end else begin
                        slot = {{(VEC_W-1){1'b0}}, 1'b1} << fill;
                        sym_words[sym] |= slot;
                        if (at_start) start_bits |= slot;
                        if (last) end_bits |= slot;
                        at_start = last;
                        fill++;
                    end
                end
                CMD_SCAN: begin
                    active_bits = ((active_bits << 1) | start_bits) & sym_words[sym];
                    r.end_hits  = active_bits & end_bits;
                    r.matched   = |r.end_hits;
                    r.position  = text_pos;
                    text_pos++;
                end
                CMD_RESTART: begin
                    active_bits = '0;
                    text_pos    = '0;
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(logic matched, logic [POSITION_W-1:0] position,
                                   logic [VEC_W-1:0] end_hits, logic overflow);
            match_result_t r;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (matched !== r.matched) begin
                $error("m_matched: expected %0d, got %0d", r.matched, matched);
                errors++;
            end
            if (position !== r.position) begin
                $error("m_position: expected %0d, got %0d", r.position, position);
                errors++;
            end
            if (end_hits !== r.end_hits) begin
                $error("m_end_hits: expected %h, got %h", r.end_hits, end_hits);
                errors++;
            end
            if (overflow !== r.overflow) begin
                $error("m_overflow: expected %0d, got %0d", r.overflow, overflow);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [COMMAND_W-1:0]  s_command;
    logic [SYMBOL_W-1:0]   s_symbol;
    logic                  s_pattern_last;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_matched;
    logic [POSITION_W-1:0] m_position;
    logic [VEC_W-1:0]      m_end_hits;
    logic                  m_overflow;

    multi_pattern_shift_and_matcher_core #(
        .STATE_BITS    (VEC_W),
        .ALPHABET_SIZE (256)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_symbol       (s_symbol),
        .s_pattern_last (s_pattern_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_matched      (m_matched),
        .m_position     (m_position),
        .m_end_hits     (m_end_hits),
        .m_overflow     (m_overflow)
    );

    match_scoreboard sb;

    // Percent of cycles in which the sender idles and the receiver stalls.
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    // Requests accepted so far.
    int unsigned sent;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous hard stop; a correct run ends far earlier.
    initial begin
        #5_000_000;
        $display("multi_pattern_shift_and_matcher_core: mismatch");
        $finish;
    end

    // Receiver: drop ready at random for the current stall rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check every result taken off the result channel.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_matched, m_position, m_end_hits, m_overflow);
        end
    end

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    // Present one request, idling first at the current rate, and hold it
    // until accepted. Valid stays high afterwards; the next call either
    // replaces the payload or drops valid.
    task automatic send_request(cmd_t cmd, logic [SYMBOL_W-1:0] sym, logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_symbol       <= sym;
        s_pattern_last <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(cmd, sym, last);
        sent++;
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Hand-picked sequence: two patterns of unequal length, an unfinished
    // pattern finished later during a search, a one-character pattern,
    // symbol extremes, and a restart.
    task automatic run_directed();
        send_request(CMD_CLEAR, 8'hA5, 1'b1);
        send_request(CMD_SCAN, 8'h00, 1'b0);        // empty table: no match
        send_request(CMD_LOAD, 8'h00, 1'b0);        // pattern 00 FF
        send_request(CMD_LOAD, 8'hFF, 1'b1);
        send_request(CMD_LOAD, 8'h41, 1'b0);        // pattern 41 42 00
        send_request(CMD_LOAD, 8'h42, 1'b0);
        send_request(CMD_LOAD, 8'h00, 1'b1);
        send_request(CMD_LOAD, 8'h7E, 1'b0);        // left unfinished
        send_request(CMD_SCAN, 8'h00, 1'b1);
        send_request(CMD_SCAN, 8'hFF, 1'b0);        // short pattern ends
        send_request(CMD_SCAN, 8'h41, 1'b0);
        send_request(CMD_SCAN, 8'h42, 1'b0);
        send_request(CMD_SCAN, 8'h00, 1'b0);        // long pattern ends
        send_request(CMD_SCAN, 8'h7E, 1'b0);        // unfinished: no hit
        send_request(CMD_RESTART, 8'hFF, 1'b0);
        send_request(CMD_SCAN, 8'h00, 1'b0);
        send_request(CMD_SCAN, 8'hFF, 1'b0);        // hit at position 1
        send_request(CMD_SCAN, 8'h7E, 1'b0);
        send_request(CMD_LOAD, 8'h01, 1'b1);        // finish 7E 01 mid-search
        send_request(CMD_SCAN, 8'h01, 1'b0);        // earlier 7E still counts
        send_request(CMD_LOAD, 8'h55, 1'b1);        // single-character pattern
        send_request(CMD_SCAN, 8'h55, 1'b0);
        send_request(CMD_SCAN, 8'h7E, 1'b0);
        send_request(CMD_SCAN, 8'h01, 1'b0);
    endtask

    // One random episode: usually a clear, a few short patterns over a tiny
    // alphabet, sometimes a flood of loads to push past the packing, then
    // text drawn mostly from that alphabet so matches happen often.
    task automatic run_segment();
        logic [SYMBOL_W-1:0] letters [4];
        int unsigned         n_pat;
        int unsigned         plen;
        int unsigned         n_text;
        int unsigned         roll;
        foreach (letters[i]) letters[i] = 8'($urandom);
        if ($urandom_range(99) < 70) begin
            send_request(CMD_CLEAR, 8'($urandom), 1'($urandom));
        end
        n_pat = $urandom_range(1, 4);
        for (int p = 0; p < n_pat; p++) begin
            plen = $urandom_range(1, 6);
            for (int k = 0; k < plen; k++) begin
                send_request(CMD_LOAD, letters[$urandom_range(3)], k == plen - 1);
            end
        end
        // flood: likely runs past the last free bit
        if ($urandom_range(9) == 0) begin
            plen = $urandom_range(30, 70);
            for (int k = 0; k < plen; k++) begin
                send_request(CMD_LOAD, 8'($urandom), 1'($urandom));
            end
        end
        n_text = $urandom_range(10, 40);
        for (int t = 0; t < n_text; t++) begin
            roll = $urandom_range(99);
            if (roll < 84) begin
                send_request(CMD_SCAN, letters[$urandom_range(3)], 1'($urandom));
            end else if (roll < 93) begin
                send_request(CMD_SCAN, 8'($urandom), 1'($urandom));
            end else if (roll < 96) begin
                send_request(CMD_RESTART, 8'($urandom), 1'($urandom));
            end else if (roll < 99) begin
                send_request(CMD_LOAD, letters[$urandom_range(3)], 1'($urandom));
            end else begin
                send_request(CMD_CLEAR, 8'($urandom), 1'($urandom));
            end
        end
    endtask

    // Run random episodes under one idle/stall mix, then drain.
    task automatic run_phase(int unsigned src_pct, int unsigned sink_pct,
                             int unsigned n_req);
        int unsigned goal;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        goal = sent + n_req;
        while (sent < goal) run_segment();
        hold_until_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb             = new();
        sent           = 0;
        src_idle_pct   = 37;
        sink_stall_pct = 51;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_command      <= CMD_CLEAR;
        s_symbol       <= '0;
        s_pattern_last <= 1'b0;

        // hold reset, then release it once
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        hold_until_drained();

        run_phase(37, 51, 410);
        run_phase(51, 37, 410);
        run_phase(0, 0, 410);

        // let any stray result show up before the verdict
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("multi_pattern_shift_and_matcher_core: match");
        end else begin
            $display("multi_pattern_shift_and_matcher_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- multi_pattern_shift_and_matcher_core.f -----
rtl/mpsa_pkg.sv
rtl/mpsa_char_table.sv
rtl/multi_pattern_shift_and_matcher_core.sv
rtl/mpsa_checker.sv
tb/multi_pattern_shift_and_matcher_core_tb.sv
